// File: sv/encoder_speed_meter_unit_defines.svh
// Assertion shorthands for the speed meter; clk and rst are taken from the enclosing module.
`ifndef ENCODER_SPEED_METER_UNIT_DEFINES_SVH
`define ENCODER_SPEED_METER_UNIT_DEFINES_SVH

// condition must hold on every cycle
`define ESM_ASSERT_NOW(lbl, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (c)) \
    else $error("esm assertion failed");

// same-cycle implication
`define ESM_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("esm assertion failed");

// next-cycle implication
`define ESM_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("esm assertion failed");

`endif

// File: sv/esm_pkg.sv
`timescale 1ns / 1ps
package esm_pkg;

  localparam int CHANNELS_DEF   = 4;
  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam int ROT_BITS   = 40;
  localparam int SPEED_BITS = 23;
  localparam int CFG_BITS   = 23;
  localparam int GR_BITS    = 10;
  localparam int PPT_BITS   = 8;
  localparam int IDX_BITS   = 2;

  // shared divider: 33-bit dividend covers 6e9, divisor covers gear * ppt * period
  localparam int DVD_BITS   = 33;
  localparam int DVS_BITS   = 50;
  localparam int MUL_A_BITS = 40;
  localparam int MUL_B_BITS = 18;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

  localparam logic [DVD_BITS-1:0]   CENTI_US_PER_MIN = 33'd6000000000;
  localparam logic [SPEED_BITS-1:0] SPEED_MAX        = 23'd6000000;

  localparam logic [GR_BITS-1:0]    GEAR_RATIO_RST = 10'd80;
  localparam logic [PPT_BITS-1:0]   PPT_RST        = 8'd2;
  localparam logic [SPEED_BITS-1:0] CUTOFF_RST     = 23'd1600;
  localparam logic [SPEED_BITS-1:0] ZERO_RST       = 23'd50;

  localparam logic [1:0] MODE_EDGE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [IDX_BITS-1:0] CFG_GEAR_RATIO = 2'd0;
  localparam logic [IDX_BITS-1:0] CFG_PPT        = 2'd1;
  localparam logic [IDX_BITS-1:0] CFG_CUTOFF     = 2'd2;
  localparam logic [IDX_BITS-1:0] CFG_ZERO       = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  channel;
    logic [31:0] timestamp_us;
  } esm_item_t;

  typedef struct packed {
    logic [1:0]            channel_out;
    logic [SPEED_BITS-1:0] speed_centi_rpm;
    logic                  used_window;
    logic                  saturated;
  } esm_result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_CHK,
    S_TICK_DIV,
    S_TICK_MUL,
    S_TICK_WB,
    S_RD_MUL1,
    S_RD_MUL2,
    S_RD_DIVE_GO,
    S_RD_DIVE,
    S_RD_MUL3,
    S_RD_DIVW_GO,
    S_RD_DIVW,
    S_RD_OUT
  } esm_state_t;

  typedef enum logic [1:0] {
    MUL_GR_PPT,
    MUL_GPP_PERIOD,
    MUL_GR_ROT,
    MUL_Q_PPT
  } esm_mul_sel_t;

  typedef enum logic {
    DIV_TICK,
    DIV_SPEED
  } esm_div_sel_t;

  typedef struct packed {
    logic         load_item;
    logic         edge_upd;
    logic         idx_inc;
    logic         rot_max;
    logic         rot_write;
    logic         div_start;
    esm_div_sel_t div_sel;
    logic         mul_load;
    esm_mul_sel_t mul_sel;
    logic         save_edge;
    logic         save_win;
    logic         out_load;
  } esm_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       ch_ok;
    logic       cnt_zero;
    logic       last_chan;
    logic       div_done;
    logic       out_free;
  } esm_stat_t;

  function automatic logic [SPEED_BITS-1:0] clamp_speed(input logic [DVD_BITS-1:0] q);
    if (q > DVD_BITS'(SPEED_MAX)) begin
      return SPEED_MAX;
    end
    return q[SPEED_BITS-1:0];
  endfunction

endpackage

// File: sv/esm_div.sv
`timescale 1ns / 1ps
module esm_div
  import esm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DVD_BITS-1:0] dividend,
  input  logic [DVS_BITS-1:0] divisor,
  output logic [DVD_BITS-1:0] quotient,
  output logic                div_zero,
  output logic                done
);

  localparam int CNT_W = $clog2(DVD_BITS);

  logic [DVS_BITS-1:0] dvs;
  logic [DVD_BITS-1:0] rem;
  logic [DVD_BITS-1:0] quo;
  logic [CNT_W-1:0]    cnt;
  logic                busy;

  logic [DVD_BITS:0]   rem_sh;
  logic [DVD_BITS:0]   diff;
  logic                ge;

  // restoring radix-2 step; quo shifts dividend bits out and quotient bits in
  assign rem_sh = {rem, quo[DVD_BITS-1]};
  assign ge     = {{(DVS_BITS-DVD_BITS-1){1'b0}}, rem_sh} >= dvs;
  assign diff   = rem_sh - dvs[DVD_BITS:0];

  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      rem      <= '0;
      quo      <= dividend;
      cnt      <= CNT_W'(DVD_BITS - 1);
      div_zero <= (divisor == '0);
    end else if (busy) begin
      rem <= ge ? diff[DVD_BITS-1:0] : rem_sh[DVD_BITS-1:0];
      quo <= {quo[DVD_BITS-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// File: sv/esm_dpath.sv
`timescale 1ns / 1ps
module esm_dpath
  import esm_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  esm_item_t           in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output esm_result_t         out_data,
  input  esm_cmd_t            cmd,
  output esm_stat_t           stat
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [GR_BITS-1:0]    gear_ratio;
  logic [PPT_BITS-1:0]   pulses_per_turn;
  logic [SPEED_BITS-1:0] cutoff_centi_rpm;
  logic [SPEED_BITS-1:0] zero_centi_rpm;

  logic [TIME_BITS-1:0]  latest_edge_time   [CHANNELS];
  logic [TIME_BITS-1:0]  previous_edge_time [CHANNELS];
  logic [COUNT_BITS-1:0] pulse_count        [CHANNELS];
  logic [TIME_BITS-1:0]  window_start_time  [CHANNELS];
  logic [ROT_BITS-1:0]   rotation_time      [CHANNELS];

  logic [TIME_BITS-1:0]  ts;
  logic [1:0]            rd_channel;
  logic [CH_W-1:0]       idx;
  logic [PROD_BITS-1:0]  prod;
  logic [SPEED_BITS-1:0] spd_e;
  logic [SPEED_BITS-1:0] spd_w;
  logic                  sat_e;
  logic                  sat_w;

  logic [CH_W-1:0]       addr;
  logic [TIME_BITS-1:0]  ts_in;
  logic [TIME_BITS-1:0]  period;
  logic [TIME_BITS-1:0]  elapsed;
  logic [MUL_A_BITS-1:0] mul_a;
  logic [MUL_B_BITS-1:0] mul_b;
  logic [PROD_BITS-1:0]  mul_p;
  logic [DVD_BITS-1:0]   div_dvd;
  logic [DVS_BITS-1:0]   div_dvs;
  logic [DVD_BITS-1:0]   div_q;
  logic                  div_zero;
  logic                  div_done;
  logic                  use_win;
  logic [SPEED_BITS-1:0] pick_speed;
  logic                  pick_sat;

  // edges write at the incoming channel, everything else at the held index
  assign addr    = cmd.load_item ? CH_W'(in_data.channel) : idx;
  assign ts_in   = in_data.timestamp_us[TIME_BITS-1:0];
  assign period  = latest_edge_time[idx] - previous_edge_time[idx];
  assign elapsed = ts - window_start_time[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      gear_ratio       <= GEAR_RATIO_RST;
      pulses_per_turn  <= PPT_RST;
      cutoff_centi_rpm <= CUTOFF_RST;
      zero_centi_rpm   <= ZERO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GEAR_RATIO: gear_ratio       <= cfg_data[GR_BITS-1:0];
        CFG_PPT:        pulses_per_turn  <= cfg_data[PPT_BITS-1:0];
        CFG_CUTOFF:     cutoff_centi_rpm <= cfg_data;
        CFG_ZERO:       zero_centi_rpm   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        latest_edge_time[i]   <= '0;
        previous_edge_time[i] <= '0;
        pulse_count[i]        <= '0;
        window_start_time[i]  <= '0;
        rotation_time[i]      <= '0;
      end
    end else begin
      if (cmd.edge_upd) begin
        previous_edge_time[addr] <= latest_edge_time[addr];
        latest_edge_time[addr]   <= ts_in;
        if (pulse_count[addr] != COUNT_MAX) begin
          pulse_count[addr] <= pulse_count[addr] + 1'b1;
        end
      end
      if (cmd.rot_max) begin
        rotation_time[addr] <= '1;
      end
      if (cmd.rot_write) begin
        rotation_time[addr]     <= prod[ROT_BITS-1:0];
        pulse_count[addr]       <= '0;
        window_start_time[addr] <= ts;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      ts         <= ts_in;
      rd_channel <= in_data.channel;
      idx        <= (in_data.mode == MODE_TICK) ? '0 : CH_W'(in_data.channel);
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_GR_PPT: begin
        mul_a = MUL_A_BITS'(gear_ratio);
        mul_b = MUL_B_BITS'(pulses_per_turn);
      end
      MUL_GPP_PERIOD: begin
        mul_a = MUL_A_BITS'(period);
        mul_b = prod[MUL_B_BITS-1:0];
      end
      MUL_GR_ROT: begin
        mul_a = rotation_time[idx];
        mul_b = MUL_B_BITS'(gear_ratio);
      end
      MUL_Q_PPT: begin
        mul_a = MUL_A_BITS'(div_q);
        mul_b = MUL_B_BITS'(pulses_per_turn);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod <= mul_p;
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_TICK: begin
        div_dvd = DVD_BITS'(elapsed);
        div_dvs = DVS_BITS'(pulse_count[idx]);
      end
      DIV_SPEED: begin
        div_dvd = CENTI_US_PER_MIN;
        div_dvs = prod[DVS_BITS-1:0];
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  esm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .div_zero (div_zero),
    .done     (div_done)
  );

  // zero divisor leaves an all-ones quotient, which clamps to the maximum
  always_ff @(posedge clk) begin
    if (cmd.save_edge) begin
      spd_e <= clamp_speed(div_q);
      sat_e <= div_zero;
    end
    if (cmd.save_win) begin
      spd_w <= clamp_speed(div_q);
      sat_w <= div_zero;
    end
  end

  assign use_win    = spd_w < cutoff_centi_rpm;
  assign pick_speed = use_win ? spd_w : spd_e;
  assign pick_sat   = use_win ? sat_w : sat_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.channel_out <= rd_channel;
      out_data.used_window <= use_win;
      if (pick_speed < zero_centi_rpm) begin
        out_data.speed_centi_rpm <= '0;
        out_data.saturated       <= 1'b0;
      end else begin
        out_data.speed_centi_rpm <= pick_speed;
        out_data.saturated       <= pick_sat;
      end
    end
  end

  assign stat.mode      = in_data.mode;
  assign stat.ch_ok     = int'(in_data.channel) < CHANNELS;
  assign stat.cnt_zero  = pulse_count[idx] == '0;
  assign stat.last_chan = idx == CH_W'(CHANNELS - 1);
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid || !out_stall;

endmodule

// File: sv/esm_ctrl.sv
`timescale 1ns / 1ps
module esm_ctrl
  import esm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  esm_stat_t stat,
  output esm_cmd_t  cmd
);

  esm_state_t state;
  esm_state_t state_next;
  logic       accept;

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && stat.mode == MODE_TICK) begin
          state_next = S_TICK_CHK;
        end else if (accept && stat.mode == MODE_READ && stat.ch_ok) begin
          state_next = S_RD_MUL1;
        end
      end
      S_TICK_CHK: begin
        if (!stat.cnt_zero) begin
          state_next = S_TICK_DIV;
        end else if (stat.last_chan) begin
          state_next = S_IDLE;
        end
      end
      S_TICK_DIV: begin
        if (stat.div_done) begin
          state_next = S_TICK_MUL;
        end
      end
      S_TICK_MUL:   state_next = S_TICK_WB;
      S_TICK_WB:    state_next = stat.last_chan ? S_IDLE : S_TICK_CHK;
      S_RD_MUL1:    state_next = S_RD_MUL2;
      S_RD_MUL2:    state_next = S_RD_DIVE_GO;
      S_RD_DIVE_GO: state_next = S_RD_DIVE;
      S_RD_DIVE: begin
        if (stat.div_done) begin
          state_next = S_RD_MUL3;
        end
      end
      S_RD_MUL3:    state_next = S_RD_DIVW_GO;
      S_RD_DIVW_GO: state_next = S_RD_DIVW;
      S_RD_DIVW: begin
        if (stat.div_done) begin
          state_next = S_RD_OUT;
        end
      end
      S_RD_OUT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_SPEED;
    cmd.mul_sel = MUL_GR_PPT;
    case (state)
      S_IDLE: begin
        cmd.load_item = accept;
        cmd.edge_upd  = accept && stat.mode == MODE_EDGE && stat.ch_ok;
      end
      S_TICK_CHK: begin
        if (stat.cnt_zero) begin
          cmd.rot_max = 1'b1;
          cmd.idx_inc = !stat.last_chan;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_TICK;
        end
      end
      S_TICK_MUL: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MUL_Q_PPT;
      end
      S_TICK_WB: begin
        cmd.rot_write = 1'b1;
        cmd.idx_inc   = !stat.last_chan;
      end
      S_RD_MUL1: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MUL_GR_PPT;
      end
      S_RD_MUL2: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MUL_GPP_PERIOD;
      end
      S_RD_DIVE_GO: cmd.div_start = 1'b1;
      S_RD_DIVE:    cmd.save_edge = stat.div_done;
      S_RD_MUL3: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MUL_GR_ROT;
      end
      S_RD_DIVW_GO: cmd.div_start = 1'b1;
      S_RD_DIVW:    cmd.save_win  = stat.div_done;
      S_RD_OUT:     cmd.out_load  = stat.out_free;
      default: ;
    endcase
  end

endmodule

// File: sv/encoder_speed_meter_unit.sv
// Encoder speed meter: four (CHANNELS) encoder channels, one item at a time. An edge item
// is absorbed while idle, without leaving the idle state. A window tick walks the channels
// one by one: a channel with no pulses only gets its rotation time set to all ones, and one
// with pulses goes through the 33-step radix-2 divider, one multiply and a write-back. A read
// makes two passes through the shared serial divider (edge speed and window speed) and three
// multiplies, plus any wait for the output register to be taken. in_stall stays high while
// an item is in progress; a finished reading sits in the output register so the next item can
// be taken while it waits for transfer.
`timescale 1ns / 1ps
`include "encoder_speed_meter_unit_defines.svh"
module encoder_speed_meter_unit
  import esm_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  esm_item_t           in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output esm_result_t         out_data
);

  esm_cmd_t  cmd;
  esm_stat_t stat;

  esm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  esm_dpath #(
    .CHANNELS   (CHANNELS),
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  `ESM_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid || !out_stall)
  `ESM_ASSERT_NXT(a_load_shows, cmd.out_load, out_valid)
  `ESM_ASSERT_NOW(a_one_state_write, $onehot0({cmd.edge_upd, cmd.rot_max, cmd.rot_write}))
  `ESM_ASSERT_NXT(a_busy_after_read, cmd.load_item && stat.mode == MODE_READ && stat.ch_ok, in_stall)

endmodule
